FILE: rtl/core/skm_pkg.sv
// Package: shared constants, types and codes of the skyline merge engine.
package skm_pkg;

    localparam int MAX_BUILDINGS = 32;
    localparam int POINT_DEPTH   = 64;
    localparam int FRAME_DEPTH   = 8;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FRAME,
        ST_LEAF0,
        ST_LEAF1,
        ST_MRD,
        ST_MEX,
        ST_TL,
        ST_TR,
        ST_CPRD,
        ST_CPWR,
        ST_ORD,
        ST_OSHOW
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOAD_LAST,
        OP_DESCEND,
        OP_ASCEND,
        OP_LEAF_RD,
        OP_LEAF_WR0,
        OP_LEAF_WR1,
        OP_MERGE_INIT,
        OP_RD_BOTH,
        OP_RD_LEFT,
        OP_RD_RIGHT,
        OP_MERGE_STEP,
        OP_TAIL_LEFT,
        OP_TAIL_RIGHT,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_COPY_DONE,
        OP_OUT_RD,
        OP_OUT_NEXT,
        OP_OUT_DONE
    } dp_op_t;

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_MERGE
    } phase_t;

    typedef struct packed {
        logic [4:0] p;
        logic [4:0] r;
        phase_t     phase;
        logic [6:0] base;
        logic [6:0] mid;
    } frame_t;

    typedef struct packed {
        dp_op_t op;
    } skm_cmd_t;

    typedef struct packed {
        logic   frame_empty;
        phase_t phase;
        logic   leaf;
        logic   left_more;
        logic   right_more;
        logic   s_full;
        logic   copy_done;
        logic   out_last;
    } skm_status_t;

endpackage

FILE: rtl/core/skm_if.sv
// Interfaces: building input channel and skyline point output channel.
interface skm_bld_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_edge;
    logic [15:0] height;
    logic [15:0] right_edge;
    logic        last_building;

    modport source (output valid, left_edge, height, right_edge, last_building,
                    input ready);
    modport sink (input valid, left_edge, height, right_edge, last_building,
                  output ready);
endinterface

interface skm_pt_if;
    logic        valid;
    logic        ready;
    logic [15:0] point_x;
    logic [15:0] point_height;
    logic        last_point;

    modport source (output valid, point_x, point_height, last_point, input ready);
    modport sink (input valid, point_x, point_height, last_point, output ready);
endinterface

FILE: rtl/core/skm_ctrl.sv
// Controller: sequencer of load, recursion walk, merge, copy and output.
module skm_ctrl
    import skm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  logic        out_ready,
    output logic        out_valid,
    input  skm_status_t status,
    output skm_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Choose next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_FRAME;
                end
            end
            ST_FRAME:
            begin
                if (status.frame_empty)
                begin
                    state_next = ST_ORD;
                end
                else if (status.phase == PH_LEFT && status.leaf)
                begin
                    state_next = ST_LEAF0;
                end
                else if (status.phase == PH_MERGE)
                begin
                    state_next = ST_MRD;
                end
            end
            ST_LEAF0: state_next = ST_LEAF1;
            ST_LEAF1: state_next = ST_FRAME;
            ST_MRD:
            begin
                if (status.left_more && status.right_more)
                begin
                    state_next = ST_MEX;
                end
                else if (status.left_more && !status.s_full)
                begin
                    state_next = ST_TL;
                end
                else if (status.right_more && !status.s_full)
                begin
                    state_next = ST_TR;
                end
                else
                begin
                    state_next = ST_CPRD;
                end
            end
            ST_MEX:   state_next = ST_MRD;
            ST_TL:    state_next = ST_MRD;
            ST_TR:    state_next = ST_MRD;
            ST_CPRD:  state_next = status.copy_done ? ST_FRAME : ST_CPWR;
            ST_CPWR:  state_next = ST_CPRD;
            ST_ORD:   state_next = ST_OSHOW;
            ST_OSHOW:
            begin
                if (out_ready)
                begin
                    state_next = status.out_last ? ST_LOAD : ST_ORD;
                end
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    // Drive commands and handshakes
    always_comb
    begin
        cmd.op    = OP_NONE;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = in_last ? OP_LOAD_LAST : OP_LOAD;
                end
            end
            ST_FRAME:
            begin
                if (!status.frame_empty)
                begin
                    case (status.phase)
                        PH_LEFT:  cmd.op = status.leaf ? OP_LEAF_RD : OP_DESCEND;
                        PH_RIGHT: cmd.op = OP_ASCEND;
                        PH_MERGE: cmd.op = OP_MERGE_INIT;
                        default:  cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_LEAF0: cmd.op = OP_LEAF_WR0;
            ST_LEAF1: cmd.op = OP_LEAF_WR1;
            ST_MRD:
            begin
                if (status.left_more && status.right_more)
                begin
                    cmd.op = OP_RD_BOTH;
                end
                else if (status.left_more && !status.s_full)
                begin
                    cmd.op = OP_RD_LEFT;
                end
                else if (status.right_more && !status.s_full)
                begin
                    cmd.op = OP_RD_RIGHT;
                end
            end
            ST_MEX:   cmd.op = OP_MERGE_STEP;
            ST_TL:    cmd.op = OP_TAIL_LEFT;
            ST_TR:    cmd.op = OP_TAIL_RIGHT;
            ST_CPRD:  cmd.op = status.copy_done ? OP_COPY_DONE : OP_COPY_RD;
            ST_CPWR:  cmd.op = OP_COPY_WR;
            ST_ORD:   cmd.op = OP_OUT_RD;
            ST_OSHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.op = status.out_last ? OP_OUT_DONE : OP_OUT_NEXT;
                end
            end
            default:  cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/core/skm_datapath.sv
// Datapath: building store, point stack, merge scratch and recursion frames.
module skm_datapath
    import skm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  skm_cmd_t    cmd,
    input  logic [15:0] left_edge,
    input  logic [15:0] height,
    input  logic [15:0] right_edge,
    output skm_status_t status,
    output logic [15:0] point_x,
    output logic [15:0] point_height
);

    logic [47:0] store_mem [MAX_BUILDINGS];
    logic [31:0] a_mem [POINT_DEPTH];
    logic [31:0] b_mem [POINT_DEPTH];
    frame_t      frame_reg [FRAME_DEPTH];

    logic [5:0]  count_reg;
    logic [3:0]  sp_reg;
    logic [6:0]  top_reg;
    logic [6:0]  i_reg;
    logic [6:0]  iend_reg;
    logic [6:0]  j_reg;
    logic [6:0]  jend_reg;
    logic [6:0]  s_reg;
    logic [6:0]  k_reg;
    logic [6:0]  o_reg;
    logic [6:0]  base_reg;
    logic [15:0] hl_reg;
    logic [15:0] hr_reg;
    logic [15:0] lasth_reg;
    logic [47:0] store_rd_reg;
    logic [31:0] rd0_reg;
    logic [31:0] rd1_reg;
    logic [31:0] brd_reg;

    frame_t      ft;
    logic [2:0]  ft_idx;
    logic [2:0]  push_idx;
    logic [5:0]  q_sum;
    logic [4:0]  q;
    logic [5:0]  cnt_new;
    logic        store_room;
    logic [15:0] xl;
    logic [15:0] xr;
    logic [15:0] hl_new;
    logic [15:0] hr_new;
    logic [15:0] h_new;
    logic [15:0] x_new;
    logic        emit;
    logic        s_full;
    logic [6:0]  top_p1;
    logic [6:0]  copy_addr;

    assign ft_idx     = 3'(sp_reg - 4'd1);
    assign push_idx   = sp_reg[2:0];
    assign ft         = frame_reg[ft_idx];
    assign q_sum      = {1'b0, ft.p} + {1'b0, ft.r} + 6'd1;
    assign q          = q_sum[5:1];
    assign store_room = (count_reg < 6'(MAX_BUILDINGS));
    assign cnt_new    = count_reg + {5'd0, store_room};
    assign s_full     = (s_reg == 7'(POINT_DEPTH));
    assign top_p1     = top_reg + 7'd1;
    assign copy_addr  = base_reg + k_reg;

    // Compare heads of both lists
    always_comb
    begin
        xl     = rd0_reg[31:16];
        xr     = rd1_reg[31:16];
        hl_new = hl_reg;
        hr_new = hr_reg;
        if (xl == xr)
        begin
            x_new  = xl;
            hl_new = rd0_reg[15:0];
            hr_new = rd1_reg[15:0];
        end
        else if (xl < xr)
        begin
            x_new  = xl;
            hl_new = rd0_reg[15:0];
        end
        else
        begin
            x_new  = xr;
            hr_new = rd1_reg[15:0];
        end
        h_new = (hl_new > hr_new) ? hl_new : hr_new;
        emit  = (s_reg == 7'd0) || (lasth_reg != h_new);
    end

    // Report status
    always_comb
    begin
        status.frame_empty = (sp_reg == 4'd0);
        status.phase       = ft.phase;
        status.leaf        = (ft.p >= ft.r);
        status.left_more   = (i_reg < iend_reg);
        status.right_more  = (j_reg < jend_reg);
        status.s_full      = s_full;
        status.copy_done   = (k_reg == s_reg);
        status.out_last    = ((o_reg + 7'd1) == top_reg);
    end

    assign point_x      = rd0_reg[31:16];
    assign point_height = rd0_reg[15:0];

    // Write and read memories
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD, OP_LOAD_LAST:
            begin
                if (store_room)
                begin
                    store_mem[count_reg[4:0]] <= {right_edge, height, left_edge};
                end
            end
            OP_LEAF_RD:    store_rd_reg <= store_mem[ft.p];
            OP_LEAF_WR0:   a_mem[top_reg[5:0]] <= {store_rd_reg[15:0], store_rd_reg[31:16]};
            OP_LEAF_WR1:   a_mem[top_p1[5:0]] <= {store_rd_reg[47:32], 16'd0};
            OP_RD_BOTH:
            begin
                rd0_reg <= a_mem[i_reg[5:0]];
                rd1_reg <= a_mem[j_reg[5:0]];
            end
            OP_RD_LEFT:    rd0_reg <= a_mem[i_reg[5:0]];
            OP_RD_RIGHT:   rd1_reg <= a_mem[j_reg[5:0]];
            OP_MERGE_STEP:
            begin
                if (emit && !s_full)
                begin
                    b_mem[s_reg[5:0]] <= {x_new, h_new};
                end
            end
            OP_TAIL_LEFT:  b_mem[s_reg[5:0]] <= rd0_reg;
            OP_TAIL_RIGHT: b_mem[s_reg[5:0]] <= rd1_reg;
            OP_COPY_RD:    brd_reg <= b_mem[k_reg[5:0]];
            OP_COPY_WR:    a_mem[copy_addr[5:0]] <= brd_reg;
            OP_OUT_RD:     rd0_reg <= a_mem[o_reg[5:0]];
            default:       ;
        endcase
    end

    // Advance counters, frames and running heights
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sp_reg    <= '0;
            top_reg   <= '0;
            i_reg     <= '0;
            iend_reg  <= '0;
            j_reg     <= '0;
            jend_reg  <= '0;
            s_reg     <= '0;
            k_reg     <= '0;
            o_reg     <= '0;
            base_reg  <= '0;
            hl_reg    <= '0;
            hr_reg    <= '0;
            lasth_reg <= '0;
            for (int n = 0; n < FRAME_DEPTH; n++)
            begin
                frame_reg[n] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_LOAD: count_reg <= cnt_new;
                OP_LOAD_LAST:
                begin
                    count_reg          <= cnt_new;
                    frame_reg[0].p     <= '0;
                    frame_reg[0].r     <= 5'(cnt_new - 6'd1);
                    frame_reg[0].phase <= PH_LEFT;
                    frame_reg[0].base  <= '0;
                    frame_reg[0].mid   <= '0;
                    sp_reg             <= 4'd1;
                    top_reg            <= '0;
                    o_reg              <= '0;
                end
                OP_DESCEND:
                begin
                    frame_reg[ft_idx].phase  <= PH_RIGHT;
                    frame_reg[push_idx].p     <= ft.p;
                    frame_reg[push_idx].r     <= q - 5'd1;
                    frame_reg[push_idx].phase <= PH_LEFT;
                    frame_reg[push_idx].base  <= top_reg;
                    sp_reg                    <= sp_reg + 4'd1;
                end
                OP_ASCEND:
                begin
                    frame_reg[ft_idx].phase  <= PH_MERGE;
                    frame_reg[ft_idx].mid    <= top_reg;
                    frame_reg[push_idx].p     <= q;
                    frame_reg[push_idx].r     <= ft.r;
                    frame_reg[push_idx].phase <= PH_LEFT;
                    frame_reg[push_idx].base  <= top_reg;
                    sp_reg                    <= sp_reg + 4'd1;
                end
                OP_LEAF_WR1:
                begin
                    top_reg <= top_reg + 7'd2;
                    sp_reg  <= sp_reg - 4'd1;
                end
                OP_MERGE_INIT:
                begin
                    i_reg    <= ft.base;
                    iend_reg <= ft.mid;
                    j_reg    <= ft.mid;
                    jend_reg <= top_reg;
                    base_reg <= ft.base;
                    s_reg    <= '0;
                    k_reg    <= '0;
                    hl_reg   <= '0;
                    hr_reg   <= '0;
                    sp_reg   <= sp_reg - 4'd1;
                end
                OP_MERGE_STEP:
                begin
                    hl_reg <= hl_new;
                    hr_reg <= hr_new;
                    if (xl <= xr)
                    begin
                        i_reg <= i_reg + 7'd1;
                    end
                    if (xr <= xl)
                    begin
                        j_reg <= j_reg + 7'd1;
                    end
                    if (emit && !s_full)
                    begin
                        s_reg     <= s_reg + 7'd1;
                        lasth_reg <= h_new;
                    end
                end
                OP_TAIL_LEFT:
                begin
                    s_reg <= s_reg + 7'd1;
                    i_reg <= i_reg + 7'd1;
                end
                OP_TAIL_RIGHT:
                begin
                    s_reg <= s_reg + 7'd1;
                    j_reg <= j_reg + 7'd1;
                end
                OP_COPY_WR:   k_reg <= k_reg + 7'd1;
                OP_COPY_DONE: top_reg <= base_reg + s_reg;
                OP_OUT_NEXT:  o_reg <= o_reg + 7'd1;
                OP_OUT_DONE:  count_reg <= '0;
                default:      ;
            endcase
        end
    end

endmodule

FILE: rtl/core/skyline_merge_engine_unit.sv
// Skyline merge engine: stores buildings, then streams the merged skyline.
// Loading accepts one building word per cycle.
// After the last building the sequencer walks the recursion frames, writes two
// points per leaf, merges each pair of halves into scratch and copies it back.
// Output: each point is read from the point stack, then offered until the sink
// takes it. Reset clears the count and the sequencer.
module skyline_merge_engine_unit
    import skm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    skm_bld_if.sink bld,
    skm_pt_if.source pt
);

    skm_cmd_t    cmd;
    skm_status_t status;

    // Sequence the work
    skm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bld.valid),
        .in_last   (bld.last_building),
        .in_ready  (bld.ready),
        .out_ready (pt.ready),
        .out_valid (pt.valid),
        .status    (status),
        .cmd       (cmd)
    );

    // Store and merge
    skm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .left_edge    (bld.left_edge),
        .height       (bld.height),
        .right_edge   (bld.right_edge),
        .status       (status),
        .point_x      (pt.point_x),
        .point_height (pt.point_height)
    );

    assign pt.last_point = status.out_last;

    // Never take a building while a point is offered
    assert property (@(posedge clk) disable iff (!rst_n) !(bld.ready && pt.valid))
        else $error("input taken while output word offered");

    // The last building starts the computation
    assert property (@(posedge clk) disable iff (!rst_n)
        (bld.valid && bld.ready && bld.last_building) |=> !bld.ready)
        else $error("still loading after last building");

    // The final point returns the block to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (pt.valid && pt.ready && pt.last_point) |=> bld.ready)
        else $error("not back to loading after last point");

endmodule

FILE: tb/skm_checker.sv
// Checker: watches both channels, predicts the skyline of each set and compares points.
module skm_checker
(
    input  logic      clk,
    input  logic      rst_n,
    skm_bld_if        bld_mon,
    skm_pt_if         pt_mon,
    output int        fail_count,
    output int        pending_points
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] h;
    } skyline_pt_t;

    typedef struct packed {
        logic [15:0] le;
        logic [15:0] ht;
        logic [15:0] re;
    } building_t;

    typedef skyline_pt_t pt_list_t[$];

    building_t   stored_bld[32];
    int          stored_cnt;
    skyline_pt_t skyline_q[$];
    logic        last_q[$];

    // Merge two sorted point lists, keeping height changes only while both have points
    function automatic pt_list_t merge_skylines(pt_list_t lft, pt_list_t rgt);
        pt_list_t    merged;
        skyline_pt_t np;
        int          i;
        int          j;
        logic [15:0] hl;
        logic [15:0] hr;
        logic [15:0] hx;
        logic [15:0] xx;
        i = 0;
        j = 0;
        hl = '0;
        hr = '0;
        while (i < lft.size() && j < rgt.size()) begin
            if (lft[i].x == rgt[j].x) begin
                xx = lft[i].x;
                hl = lft[i].h;
                hr = rgt[j].h;
                i++;
                j++;
            end
            else if (lft[i].x < rgt[j].x) begin
                xx = lft[i].x;
                hl = lft[i].h;
                i++;
            end
            else begin
                xx = rgt[j].x;
                hr = rgt[j].h;
                j++;
            end
            hx = (hl > hr) ? hl : hr;
            if ((merged.size() == 0 || merged[$].h != hx) && merged.size() < 64) begin
                np.x = xx;
                np.h = hx;
                merged = {merged, np};
            end
        end
        while (i < lft.size() && merged.size() < 64) begin
            merged = {merged, lft[i]};
            i++;
        end
        while (j < rgt.size() && merged.size() < 64) begin
            merged = {merged, rgt[j]};
            j++;
        end
        return merged;
    endfunction

    // Split the index range at (p+r+1)/2 and merge the halves
    function automatic pt_list_t build_skyline(int p, int r);
        pt_list_t    leaf;
        skyline_pt_t np;
        int          q;
        if (p >= r) begin
            np.x = stored_bld[p].le;
            np.h = stored_bld[p].ht;
            leaf = {leaf, np};
            np.x = stored_bld[p].re;
            np.h = 16'd0;
            leaf = {leaf, np};
            return leaf;
        end
        q = (p + r + 1) / 2;
        return merge_skylines(build_skyline(p, q - 1), build_skyline(q, r));
    endfunction

    assign pending_points = skyline_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pt_list_t    sky;
        skyline_pt_t want;
        logic        want_last;
        if (!rst_n) begin
            stored_cnt <= 0;
            fail_count <= 0;
        end
        else begin
            // Store the building word and predict on the last one
            if (bld_mon.valid && bld_mon.ready) begin
                if (stored_cnt < 32) begin
                    stored_bld[stored_cnt] = '{le: bld_mon.left_edge, ht: bld_mon.height,
                                               re: bld_mon.right_edge};
                    stored_cnt = stored_cnt + 1;
                end
                if (bld_mon.last_building) begin
                    sky = build_skyline(0, stored_cnt - 1);
                    foreach (sky[k]) begin
                        skyline_q = {skyline_q, sky[k]};
                        last_q = {last_q, logic'(k == sky.size() - 1)};
                    end
                    stored_cnt = 0;
                end
            end
            // Compare each point word with the oldest expectation
            if (pt_mon.valid && pt_mon.ready) begin
                if (skyline_q.size() == 0) begin
                    $display("%0t: unexpected point x=%0d h=%0d last=%0d", $time,
                             pt_mon.point_x, pt_mon.point_height, pt_mon.last_point);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = skyline_q.pop_front();
                    want_last = last_q.pop_front();
                    if (pt_mon.point_x !== want.x || pt_mon.point_height !== want.h ||
                        pt_mon.last_point !== want_last) begin
                        $display("%0t: mismatch expected x=%0d h=%0d last=%0d,",
                                 $time, want.x, want.h, want_last,
                                 " actual x=%0d h=%0d last=%0d", pt_mon.point_x,
                                 pt_mon.point_height, pt_mon.last_point);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top: drives building sets, stalls the point sink and gives the verdict.
module tb;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_points;
    int   cycle_cnt;
    logic hold_sink;
    logic stim_done;

    skm_bld_if bld();
    skm_pt_if  pt();

    skyline_merge_engine_unit dut (.clk(clk), .rst_n(rst_n), .bld(bld), .pt(pt));
    skm_checker chk (.clk(clk), .rst_n(rst_n), .bld_mon(bld), .pt_mon(pt),
                     .fail_count(fail_count), .pending_points(pending_points));

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Offer one building word and hold it until accepted
    task automatic send_building(logic [15:0] le, logic [15:0] ht, logic [15:0] re,
                                 logic lst);
        bld.valid <= 1;
        bld.left_edge <= le;
        bld.height <= ht;
        bld.right_edge <= re;
        bld.last_building <= lst;
        while (!bld.ready) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        bld.valid <= 0;
        bld.left_edge <= 16'($urandom);
        repeat (n) @(negedge clk);
    endtask

    // Send one set of random buildings, mostly narrow sets
    task automatic send_random_set(int n);
        logic [15:0] le;
        for (int k = 0; k < n; k++) begin
            le = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
            case ($urandom_range(0, 9))
                0: send_building(le, 16'($urandom), 16'($urandom), k == n - 1);
                1: send_building(le, 16'd0, 16'(le + $urandom_range(0, 30)), k == n - 1);
                default: send_building(le, $urandom_range(0, 3) == 0 ? 16'($urandom)
                                       : 16'($urandom_range(1, 20)),
                                       16'(le + $urandom_range(1, 60)), k == n - 1);
            endcase
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 12));
        end
    endtask

    task automatic wait_drained();
        bld.valid <= 0;
        while (pending_points != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Sink stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_sink)
            pt.ready <= 0;
        else
            pt.ready <= ($urandom_range(0, 99) < 65) || stim_done;
    end

    // Limit the run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int n;
        cycle_cnt = 0;
        hold_sink = 0;
        stim_done = 0;
        rst_n = 0;
        bld.valid = 0;
        bld.left_edge = 0;
        bld.height = 0;
        bld.right_edge = 0;
        bld.last_building = 0;
        pt.ready = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // Directed: single building, extremes, zero height, degenerate
        send_building(16'd0, 16'hffff, 16'hffff, 1);
        send_building(16'hffff, 16'd0, 16'd0, 1);
        send_building(16'd5, 16'd0, 16'd5, 1);
        send_building(16'd10, 16'd3, 16'd20, 0);
        send_building(16'd10, 16'd3, 16'd20, 1);
        send_building(16'd1, 16'd5, 16'd10, 0);
        send_building(16'd3, 16'd8, 16'd6, 0);
        send_building(16'd10, 16'd5, 16'd12, 1);
        wait_drained();
        // Full store: 33rd building dropped, last flag still honored
        for (int k = 0; k < 33; k++)
            send_building(16'(k * 3), 16'(k + 1), 16'(k * 3 + 5), k == 32);
        wait_drained();
        // Long sink hold-off while the sender keeps offering
        hold_sink = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_sink = 0;
            end
            begin
                for (int s = 0; s < 3; s++) send_random_set($urandom_range(4, 10));
            end
        join
        wait_drained();
        // Random sets
        sent = 0;
        while (sent < 160) begin
            n = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 8);
            send_random_set(n);
            sent += n;
            if ($urandom_range(0, 5) == 0) wait_drained();
            else idle_gap($urandom_range(1, 20));
        end
        stim_done = 1;
        wait_drained();
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending_points == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/skm_pkg.sv
rtl/core/skm_if.sv
rtl/core/skm_ctrl.sv
rtl/core/skm_datapath.sv
rtl/core/skyline_merge_engine_unit.sv
tb/skm_checker.sv
tb/tb.sv
